// ===== design/transpose_boxsum_square_matrix_unit_defines.svh =====
// Assertion macros used by the checker file of the matrix unit.
`ifndef TRANSPOSE_BOXSUM_SQUARE_MATRIX_UNIT_DEFINES_SVH
`define TRANSPOSE_BOXSUM_SQUARE_MATRIX_UNIT_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define TBSM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tbsm checker: same-cycle property failed");

// Next-cycle implication under the active-low reset.
`define TBSM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tbsm checker: next-cycle property failed");

`endif

// ===== design/tbsm_pkg.sv =====
package tbsm_pkg;

    // Default largest matrix dimension.
    localparam int MAX_DIM_DEF = 8;

    // Field and datapath widths.
    localparam int SIZE_W = 4;
    localparam int ELEM_W = 16;
    localparam int BOX_W  = 20;
    localparam int PROD_W = 40;
    localparam int RES_W  = 41;
    localparam int IDX_W  = 3;
    localparam int STEP_W = 4;

    // Index of the last of the nine box-sum neighbors.
    localparam logic [STEP_W-1:0] NB_LAST = 4'd8;

    // Neighbor offset codes along one axis.
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    // Control that travels with each operand pair through the shared unit.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             mul;
        logic             live;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tbsm_ctl_t;

    // Finished accumulation leaving the shared unit.
    typedef struct packed {
        logic                    done;
        logic                    mul;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [RES_W-1:0] value;
    } tbsm_res_t;

    // Row and column offset codes of neighbor j, scanned row by row.
    function automatic logic [3:0] nb_offset(input logic [STEP_W-1:0] j);
        logic [3:0] ofs;
        case (j)
            4'd0:    ofs = {OFS_MINUS, OFS_MINUS};
            4'd1:    ofs = {OFS_MINUS, OFS_ZERO};
            4'd2:    ofs = {OFS_MINUS, OFS_PLUS};
            4'd3:    ofs = {OFS_ZERO,  OFS_MINUS};
            4'd4:    ofs = {OFS_ZERO,  OFS_ZERO};
            4'd5:    ofs = {OFS_ZERO,  OFS_PLUS};
            4'd6:    ofs = {OFS_PLUS,  OFS_MINUS};
            4'd7:    ofs = {OFS_PLUS,  OFS_ZERO};
            4'd8:    ofs = {OFS_PLUS,  OFS_PLUS};
            default: ofs = {OFS_ZERO,  OFS_ZERO};
        endcase
        return ofs;
    endfunction

endpackage

// ===== design/tbsm_if.sv =====
// Input element channel.
interface tbsm_in_if;
    import tbsm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

// Result element channel.
interface tbsm_out_if;
    import tbsm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic [IDX_W-1:0]        result_row;
    logic [IDX_W-1:0]        result_col;
    logic                    last_result;

    modport source (output valid, output result_value, output result_row,
                    output result_col, output last_result, input ready);
    modport sink   (input valid, input result_value, input result_row,
                    input result_col, input last_result, output ready);
endinterface

// Size register write channel.
interface tbsm_cfg_if;
    import tbsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

// ===== design/tbsm_mac.sv =====
module tbsm_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tbsm_pkg::tbsm_ctl_t              ctl_in,
    input  logic signed [tbsm_pkg::BOX_W-1:0] a,
    input  logic signed [tbsm_pkg::BOX_W-1:0] b,
    output tbsm_pkg::tbsm_res_t              res_out,
    output logic                             busy
);
    import tbsm_pkg::*;

    tbsm_ctl_t                ctl2_reg;
    tbsm_ctl_t                ctl3_reg;
    logic signed [PROD_W-1:0] term_reg;
    logic signed [PROD_W-1:0] term_next;
    logic signed [RES_W-1:0]  acc_reg;
    logic signed [RES_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] a_ext;
    logic signed [RES_W-1:0]  term_ext;

    // Signed product of two sign-extended box sums.
    assign prod     = PROD_W'(a) * PROD_W'(b);
    assign a_ext    = PROD_W'(a);
    assign term_ext = RES_W'(term_reg);

    // First stage: a product in multiply mode, the plain operand in add mode, zero for a term that is not live.
    always_comb
    begin
        if (!ctl_in.live)
        begin
            term_next = '0;
        end
        else if (ctl_in.mul)
        begin
            term_next = prod;
        end
        else
        begin
            term_next = a_ext;
        end
    end

    // Second stage: accumulate, restarting on the first term of a sum.
    always_comb
    begin
        if (ctl2_reg.first)
        begin
            acc_next = term_ext;
        end
        else
        begin
            acc_next = acc_reg + term_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // A sum is complete when its last term has been added.
    assign res_out.done  = ctl3_reg.valid && ctl3_reg.last;
    assign res_out.mul   = ctl3_reg.mul;
    assign res_out.row   = ctl3_reg.row;
    assign res_out.col   = ctl3_reg.col;
    assign res_out.value = acc_reg;
    assign busy          = ctl2_reg.valid || ctl3_reg.valid;

endmodule

// ===== design/transpose_boxsum_square_matrix_unit.sv =====
// Loads an n x n signed matrix (n from size_in_use: 0 acts as 1, values above MAX_DIM act as
// MAX_DIM) one element per transaction in row-major order, stores it transposed, replaces each
// element by its 3x3 in-bounds box sum and emits the square of that matrix, n*n result
// transactions in row-major order with the last one marked. Loading accepts one element per
// cycle while no size write is pending. All arithmetic then runs through one pipelined
// multiply-accumulate unit fed by a small sequencer: every box sum adds nine neighbor terms;
// the pipeline drains after the last cell; and each result element is n multiply-accumulates
// followed by the memory read, the pipeline and the output register handshake. The input is
// not ready from the final element of a matrix until its last result is computed. Writing
// size_in_use restarts the load and drops elements loaded so far; size writes are accepted
// only while the block is loading, and a pending size write holds off the element input.
// The matrix stores are not cleared at reset.
module transpose_boxsum_square_matrix_unit #(
    parameter int MAX_DIM = tbsm_pkg::MAX_DIM_DEF
) (
    input logic        clk,
    input logic        rst_n,
    tbsm_in_if.sink    src,
    tbsm_out_if.source res,
    tbsm_cfg_if.sink   cfg
);
    import tbsm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        S_LOAD     = 5'b00001,
        S_BOX      = 5'b00010,
        S_DRAIN    = 5'b00100,
        S_SQ_ISSUE = 5'b01000,
        S_SQ_WAIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Matrix stores.
    logic signed [ELEM_W-1:0] tmem [DEPTH];
    logic signed [BOX_W-1:0]  bmem [DEPTH];
    logic signed [ELEM_W-1:0] t_rd_reg;
    logic signed [BOX_W-1:0]  ba_rd_reg;
    logic signed [BOX_W-1:0]  bb_rd_reg;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;

    tbsm_ctl_t ctl_issue;
    tbsm_ctl_t ctl1_reg;
    tbsm_res_t mac_res;
    logic      mac_busy;
    logic signed [BOX_W-1:0] mac_a;

    // Output register.
    logic                    ovalid_reg;
    logic signed [RES_W-1:0] oval_reg;
    logic [IDX_W-1:0]        orow_reg;
    logic [IDX_W-1:0]        ocol_reg;
    logic                    olast_reg;

    logic [SIZE_W-1:0] dim;
    logic [IDX_W-1:0]  lim;
    logic              at_last_row;
    logic              at_last_col;
    logic              in_fire;
    logic              cfg_fire;
    logic              out_fire;
    logic [3:0]        ofs;
    logic [IDX_W-1:0]  nb_row;
    logic [IDX_W-1:0]  nb_col;
    logic              nb_row_ok;
    logic              nb_col_ok;
    logic [AW-1:0]     nb_addr;
    logic [IDX_W-1:0]  k_idx;
    logic              last_k;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Effective dimension and its last index.
    always_comb
    begin
        if (size_reg == '0)
        begin
            dim = SIZE_W'(1);
        end
        else if (int'(size_reg) > MAX_DIM)
        begin
            dim = SIZE_W'(MAX_DIM);
        end
        else
        begin
            dim = size_reg;
        end
    end

    assign lim         = IDX_W'(dim - SIZE_W'(1));
    assign at_last_row = (row_reg == lim);
    assign at_last_col = (col_reg == lim);
    assign in_fire     = src.valid && src.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign out_fire    = res.valid && res.ready;

    // Neighbor address for the box sum; out-of-bounds neighbors add nothing.
    assign ofs = nb_offset(step_reg);

    always_comb
    begin
        case (ofs[3:2])
            OFS_MINUS:
            begin
                nb_row    = row_reg - IDX_W'(1);
                nb_row_ok = (row_reg != '0);
            end
            OFS_PLUS:
            begin
                nb_row    = row_reg + IDX_W'(1);
                nb_row_ok = !at_last_row;
            end
            default:
            begin
                nb_row    = row_reg;
                nb_row_ok = 1'b1;
            end
        endcase
        case (ofs[1:0])
            OFS_MINUS:
            begin
                nb_col    = col_reg - IDX_W'(1);
                nb_col_ok = (col_reg != '0);
            end
            OFS_PLUS:
            begin
                nb_col    = col_reg + IDX_W'(1);
                nb_col_ok = !at_last_col;
            end
            default:
            begin
                nb_col    = col_reg;
                nb_col_ok = 1'b1;
            end
        endcase
    end

    assign nb_addr = (nb_row_ok && nb_col_ok) ? addr_of(nb_row, nb_col) : '0;
    assign k_idx   = step_reg[IDX_W-1:0];
    assign last_k  = (k_idx == lim);

    // Sequencer: load, box sum, drain, then one product element at a time.
    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        ctl_issue  = '0;
        rd_a_addr  = '0;
        rd_b_addr  = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (at_last_row && at_last_col)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        step_next  = '0;
                        state_next = S_BOX;
                    end
                    else if (at_last_col)
                    begin
                        col_next = '0;
                        row_next = row_reg + IDX_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
                if (cfg_fire)
                begin
                    size_next = cfg.size_in_use;
                    row_next  = '0;
                    col_next  = '0;
                end
            end

            S_BOX:
            begin
                ctl_issue.valid = 1'b1;
                ctl_issue.first = (step_reg == '0);
                ctl_issue.last  = (step_reg == NB_LAST);
                ctl_issue.mul   = 1'b0;
                ctl_issue.live  = nb_row_ok && nb_col_ok;
                ctl_issue.row   = row_reg;
                ctl_issue.col   = col_reg;
                rd_a_addr       = nb_addr;
                if (step_reg == NB_LAST)
                begin
                    step_next = '0;
                    if (at_last_col)
                    begin
                        col_next = '0;
                        if (at_last_row)
                        begin
                            row_next   = '0;
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            row_next = row_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            S_DRAIN:
            begin
                // The last box sum must be written before products read it.
                if (!ctl1_reg.valid && !mac_busy)
                begin
                    state_next = S_SQ_ISSUE;
                end
            end

            S_SQ_ISSUE:
            begin
                // A new element starts only once the output register is free.
                if (!(step_reg == '0 && ovalid_reg))
                begin
                    ctl_issue.valid = 1'b1;
                    ctl_issue.first = (step_reg == '0);
                    ctl_issue.last  = last_k;
                    ctl_issue.mul   = 1'b1;
                    ctl_issue.live  = 1'b1;
                    ctl_issue.row   = row_reg;
                    ctl_issue.col   = col_reg;
                    rd_a_addr       = addr_of(row_reg, k_idx);
                    rd_b_addr       = addr_of(k_idx, col_reg);
                    if (last_k)
                    begin
                        step_next  = '0;
                        state_next = S_SQ_WAIT;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end

            S_SQ_WAIT:
            begin
                if (mac_res.done)
                begin
                    if (at_last_col)
                    begin
                        col_next = '0;
                        if (at_last_row)
                        begin
                            row_next   = '0;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            row_next   = row_reg + IDX_W'(1);
                            state_next = S_SQ_ISSUE;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + IDX_W'(1);
                        state_next = S_SQ_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            size_reg  <= SIZE_W'(MAX_DIM);
            row_reg   <= '0;
            col_reg   <= '0;
            step_reg  <= '0;
            ctl1_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
            ctl1_reg  <= ctl_issue;
        end
    end

    // Stores: the source goes in transposed, box sums come back from the unit.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && in_fire)
        begin
            tmem[addr_of(col_reg, row_reg)] <= src.element_value;
        end
        if (mac_res.done && !mac_res.mul)
        begin
            bmem[addr_of(mac_res.row, mac_res.col)] <= mac_res.value[BOX_W-1:0];
        end
        t_rd_reg  <= tmem[rd_a_addr];
        ba_rd_reg <= bmem[rd_a_addr];
        bb_rd_reg <= bmem[rd_b_addr];
    end

    // Box-sum terms are sign-extended source elements.
    assign mac_a = ctl1_reg.mul ? ba_rd_reg
                                : {{(BOX_W - ELEM_W){t_rd_reg[ELEM_W-1]}}, t_rd_reg};

    tbsm_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl1_reg),
        .a       (mac_a),
        .b       (bb_rd_reg),
        .res_out (mac_res),
        .busy    (mac_busy)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (mac_res.done && mac_res.mul)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (mac_res.done && mac_res.mul)
        begin
            oval_reg  <= mac_res.value;
            orow_reg  <= mac_res.row;
            ocol_reg  <= mac_res.col;
            olast_reg <= (mac_res.row == lim) && (mac_res.col == lim);
        end
    end

    // A size write takes precedence over an element offered in the same cycle.
    assign src.ready        = (state_reg == S_LOAD) && !cfg.valid;
    assign cfg.ready        = (state_reg == S_LOAD);
    assign res.valid        = ovalid_reg;
    assign res.result_value = oval_reg;
    assign res.result_row   = orow_reg;
    assign res.result_col   = ocol_reg;
    assign res.last_result  = olast_reg;

endmodule

// ===== design/tbsm_checker.sv =====
`include "transpose_boxsum_square_matrix_unit_defines.svh"

module tbsm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [tbsm_pkg::RES_W-1:0] out_value,
    input logic [tbsm_pkg::IDX_W-1:0]       out_row,
    input logic [tbsm_pkg::IDX_W-1:0]       out_col,
    input logic                             out_last
);

    // A stalled result stays in place.
    `TBSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last))

    // The final element of a square matrix sits on the diagonal.
    `TBSM_ASSERT_IMPL(a_last_diag, clk, rst_n, out_valid && out_last, out_row == out_col)

    // Loading resumes only after every element but the last has gone out.
    `TBSM_ASSERT_IMPL(a_no_load_mid, clk, rst_n, out_valid && !out_last, !in_ready)

endmodule

bind transpose_boxsum_square_matrix_unit tbsm_checker u_tbsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (src.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_value (res.result_value),
    .out_row   (res.result_row),
    .out_col   (res.result_col),
    .out_last  (res.last_result)
);

// ===== tb/sv/matrix_square_checker.sv =====
`timescale 1ns / 100ps

// Watches the element, result and size channels of the matrix unit, keeps its own
// copy of the loaded matrix, and checks every result transaction against the
// square of the box-summed transposed matrix.
module matrix_square_checker
    import tbsm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tbsm_in_if   src_mon,
    tbsm_out_if  res_mon,
    tbsm_cfg_if  cfg_mon,
    output int   mismatch_count,
    output int   pending_results,
    output int   results_seen,
    output int   matrices_done
);

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } square_elem_t;

    logic [SIZE_W-1:0]        size_reg;
    // Source elements, held transposed: element (r, c) of the source sits at c*MAX_DIM + r.
    logic signed [ELEM_W-1:0] transposed_elems [MAX_DIM*MAX_DIM];
    int                       load_count;
    square_elem_t             square_q [$];

    // Matrix dimension selected by the size register.
    function automatic int dim_of(input logic [SIZE_W-1:0] s);
        if (s == '0)
            return 1;
        if (s > MAX_DIM)
            return MAX_DIM;
        return int'(s);
    endfunction

    // Box-sums the transposed matrix and queues every element of its square, row-major.
    task automatic queue_square(input int n);
        longint       box [MAX_DIM*MAX_DIM];
        longint       acc;
        int           rr;
        int           cc;
        square_elem_t e;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                acc = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if (rr >= 0 && rr < n && cc >= 0 && cc < n)
                            acc += transposed_elems[rr*MAX_DIM + cc];
                    end
                end
                box[r*MAX_DIM + c] = acc;
            end
        end
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += box[r*MAX_DIM + k] * box[k*MAX_DIM + c];
                e.value = acc[RES_W-1:0];
                e.row   = IDX_W'(r);
                e.col   = IDX_W'(c);
                e.last  = (r == n - 1) && (c == n - 1);
                square_q.push_back(e);
            end
        end
    endtask

    // Track size writes and loaded elements, and compare result transactions.
    always @(posedge clk or negedge rst_n)
    begin
        int           n;
        square_elem_t e;
        if (!rst_n)
        begin
            size_reg = SIZE_W'(MAX_DIM);
            load_count = 0;
            square_q.delete();
            mismatch_count = 0;
            results_seen = 0;
            matrices_done = 0;
        end
        else
        begin
            // A size write restarts the load.
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                size_reg = cfg_mon.size_in_use;
                load_count = 0;
            end

            if (src_mon.valid && src_mon.ready)
            begin
                n = dim_of(size_reg);
                if (load_count >= n * n)
                    load_count = 0;
                transposed_elems[(load_count % n)*MAX_DIM + load_count / n] =
                    src_mon.element_value;
                load_count++;
                if (load_count == n * n)
                begin
                    load_count = 0;
                    queue_square(n);
                end
            end

            if (res_mon.valid && res_mon.ready)
            begin
                results_seen++;
                if (square_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result transaction value %0d at (%0d,%0d)",
                             $time, res_mon.result_value, res_mon.result_row,
                             res_mon.result_col);
                end
                else
                begin
                    e = square_q.pop_front();
                    if (res_mon.result_value !== e.value)
                    begin
                        mismatch_count++;
                        $display("%0t: result_value at (%0d,%0d): expected %0d, actual %0d",
                                 $time, e.row, e.col, e.value, res_mon.result_value);
                    end
                    if (res_mon.result_row !== e.row)
                    begin
                        mismatch_count++;
                        $display("%0t: result_row: expected %0d, actual %0d",
                                 $time, e.row, res_mon.result_row);
                    end
                    if (res_mon.result_col !== e.col)
                    begin
                        mismatch_count++;
                        $display("%0t: result_col: expected %0d, actual %0d",
                                 $time, e.col, res_mon.result_col);
                    end
                    if (res_mon.last_result !== e.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last_result at (%0d,%0d): expected %0d, actual %0d",
                                 $time, e.row, e.col, e.last, res_mon.last_result);
                    end
                    if (e.last)
                        matrices_done++;
                end
            end
        end
        pending_results = square_q.size();
    end

endmodule

// ===== tb/sv/transpose_boxsum_square_matrix_unit_tb.sv =====
`timescale 1ns / 100ps

module transpose_boxsum_square_matrix_unit_tb;
    import tbsm_pkg::*;

    localparam int ELEMENT_TARGET = 270;

    logic clk = 1'b0;
    logic rst_n;

    tbsm_in_if  src_ch ();
    tbsm_out_if res_ch ();
    tbsm_cfg_if cfg_ch ();

    int  mismatch_count;
    int  pending_results;
    int  results_seen;
    int  matrices_done;

    int          elements_loaded;
    int          elements_dropped;
    int          burst_left;
    bit          gaps_on;
    bit          hold_armed;
    logic [15:0] sizes_written;

    transpose_boxsum_square_matrix_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    matrix_square_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .src_mon         (src_ch),
        .res_mon         (res_ch),
        .cfg_mon         (cfg_ch),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen),
        .matrices_done   (matrices_done)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Random element, biased toward the extremes and small values.
    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return ELEM_W'($urandom_range(0, 16)) - 16'sd8;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Offers one element transaction and returns at the falling edge after it is taken.
    // Called at a falling edge; leaves valid high for the next element.
    task automatic push_element(input logic signed [ELEM_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(1, 8);
                src_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        src_ch.valid <= 1'b1;
        src_ch.element_value <= v;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        elements_loaded++;
    endtask

    // Drops valid, waits for every queued result, then lets the block go quiet.
    task automatic settle();
        src_ch.valid <= 1'b0;
        wait (pending_results == 0);
        repeat (30) @(negedge clk);
    endtask

    // One size register write transaction, started at a falling edge.
    task automatic write_size(input logic [SIZE_W-1:0] s);
        cfg_ch.valid <= 1'b1;
        cfg_ch.size_in_use <= s;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        sizes_written[s] = 1'b1;
    endtask

    // Result sink: changing stall patterns, plus one long hold-off when armed.
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int tick;
        res_ch.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_armed && res_ch.valid)
            begin
                hold_armed = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int                phase_no;
        logic [SIZE_W-1:0] size_val;
        int                dim;
        int                mats;
        int                cut;
        src_ch.valid = 1'b0;
        src_ch.element_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.size_in_use = '0;
        rst_n = 1'b0;
        hold_armed = 1'b0;
        gaps_on = 1'b1;
        burst_left = 0;
        elements_loaded = 0;
        elements_dropped = 0;
        sizes_written = '0;
        phase_no = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Size zero behaves as a 1x1 matrix; each element is a whole matrix.
        write_size(4'd0);
        push_element(16'sh7FFF);
        push_element(16'sh8000);
        push_element(-16'sd1);
        settle();

        // 2x2 of all minimum, then all maximum while the result side holds off.
        write_size(4'd2);
        repeat (4) push_element(16'sh8000);
        hold_armed = 1'b1;
        repeat (4) push_element(16'sh7FFF);
        settle();

        // Rewriting the size in the middle of a load drops the partial matrix.
        write_size(4'd3);
        repeat (5) push_element(pick_element());
        settle();
        write_size(4'd3);
        elements_loaded -= 5;
        elements_dropped += 5;
        push_element(16'sh7FFF);
        push_element(16'sh8000);
        push_element(16'sd0);
        push_element(-16'sd1);
        push_element(16'sd1);
        push_element(16'sh5555);
        push_element(-16'sh5556);
        push_element(16'sh7FFF);
        push_element(16'sh8000);
        settle();

        // Random phases: a size write, sometimes a broken load, then whole matrices.
        while (elements_loaded < ELEMENT_TARGET)
        begin
            if (phase_no == 0)
                size_val = 4'd15;
            else if (phase_no == 1)
                size_val = 4'd8;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       size_val = 4'd0;
                    1:       size_val = SIZE_W'($urandom_range(9, 15));
                    default: size_val = SIZE_W'($urandom_range(1, 7));
                endcase
            end
            dim = (size_val == 0) ? 1 : ((size_val > MAX_DIM_DEF) ? MAX_DIM_DEF : size_val);
            gaps_on = ($urandom_range(0, 3) != 0);
            write_size(size_val);

            if (dim > 1 && $urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, dim * dim - 1);
                repeat (cut) push_element(pick_element());
                settle();
                write_size(size_val);
                elements_loaded -= cut;
                elements_dropped += cut;
            end

            if (dim <= 3)
                mats = $urandom_range(2, 4);
            else if (dim <= 6)
                mats = $urandom_range(1, 2);
            else
                mats = 1;
            repeat (mats * dim * dim) push_element(pick_element());
            settle();
            phase_no++;
        end

        wait (pending_results == 0);
        repeat (40) @(posedge clk);
        $display("Run: %0d elements in completed loads, %0d dropped by size rewrites,",
                 elements_loaded, elements_dropped);
        $display("     %0d result transactions over %0d matrices; sizes written (15..0) %b",
                 results_seen, matrices_done, sizes_written);
        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
